// ===== rtl/core/sorted_priority_queue_top_defines.svh =====
// Assertion macros for the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Package: sizes, status codes, opcodes, controller states and command/status bundles.
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_COMPARE,
        ST_DEQ_WAIT,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // capture the request beat
        logic    read;        // read entry idx-1
        logic    shift;       // move read entry up to idx, step idx down
        logic    place;       // write new value at idx, grow fill
        logic    take;        // keep read entry as result, shrink fill
        logic    set_status;  // record status code
        status_t status;
        logic    emit;        // load the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_dequeue;
        logic full;
        logic empty;
        logic idx_zero;
        logic greater;        // read entry above new value
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
`default_nettype none

interface spq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   opcode;
    logic signed [spq_pkg::DATA_W-1:0]      value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface spq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [spq_pkg::DATA_W-1:0]      value_out;
    logic [1:0]                             status;
    logic                                   now_empty;

    modport source (output valid, output value_out, output status, output now_empty,
                    input ready);
    modport sink   (input valid, input value_out, input status, input now_empty,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted max-priority queue: ties the controller to the datapath.
//
// req channel carries one beat per operation: opcode 0 inserts value_in, opcode 1
// removes the largest stored value. rsp channel returns one beat per request with
// value_out (removed value, else zero), status (ok, dequeue on empty, enqueue
// dropped because full) and now_empty. Equal values leave newest first.
// One request is in work at a time. Stored values sit in a single-port RAM in
// ascending order with the largest at the top, so a dequeue is one read and an
// enqueue walks down from the top, moving larger entries up one at a time.
// From acceptance to the FINISH state that loads the rsp register, a rejected
// request or an enqueue into an empty queue passes DECIDE, a dequeue DECIDE and
// DEQ_WAIT, and an enqueue DECIDE and COMPARE passes that move larger entries
// up until it is placed. The next request is accepted in the cycle after the
// rsp load. Reset clears the fill count and the controller; the RAM is not
// cleared and no location is read before it is written.
// A stalled rsp holds its beat; a finished result waits for the register to free
// up while the queue state is already updated, and a new request is taken as
// soon as the result has moved into the rsp register.
`default_nettype none

module sorted_priority_queue_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    spq_pkg::dp_cmd_t   cmd;
    spq_pkg::dp_stat_t  stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
// Datapath: value store, fill count, insertion index, result and output registers.
`default_nettype none

module spq_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    spq_req_if.sink                 req,
    spq_rsp_if.source               rsp,
    input  wire spq_pkg::dp_cmd_t   cmd,
    output spq_pkg::dp_stat_t       stat
);

    // Values kept ascending by address, largest at fill-1
    logic signed [spq_pkg::DATA_W-1:0]  mem [spq_pkg::DEPTH];

    logic [spq_pkg::CNT_W-1:0]          fill_reg, fill_next;
    logic [spq_pkg::CNT_W-1:0]          idx_reg, idx_next;
    logic [spq_pkg::CNT_W-1:0]          idx_dec;
    logic signed [spq_pkg::DATA_W-1:0]  val_reg;
    logic                               op_reg;
    logic signed [spq_pkg::DATA_W-1:0]  rdata_reg;
    logic signed [spq_pkg::DATA_W-1:0]  res_value_reg;
    spq_pkg::status_t                   res_status_reg;
    logic                               out_valid_reg, out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0]  out_value_reg;
    logic [1:0]                         out_status_reg;
    logic                               out_empty_reg;
    logic                               mem_we;
    logic signed [spq_pkg::DATA_W-1:0]  mem_wdata;

    assign idx_dec   = idx_reg - spq_pkg::CNT_W'(1);
    assign mem_we    = cmd.shift | cmd.place;
    assign mem_wdata = cmd.shift ? rdata_reg : val_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg[spq_pkg::ADDR_W-1:0]] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[idx_dec[spq_pkg::ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.place)
        begin
            fill_next = fill_reg + spq_pkg::CNT_W'(1);
        end
        else if (cmd.take)
        begin
            fill_next = fill_reg - spq_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = fill_reg;
        end
        else if (cmd.shift)
        begin
            idx_next = idx_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            val_reg        <= req.value_in;
            op_reg         <= req.opcode;
            res_value_reg  <= '0;
            res_status_reg <= spq_pkg::STATUS_OK;
        end
        if (cmd.take)
        begin
            res_value_reg <= rdata_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
    end

    // Output register: hold the beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_empty_reg  <= (fill_reg == '0);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.now_empty = out_empty_reg;

    assign stat.is_dequeue = (op_reg == spq_pkg::OP_DEQUEUE);
    assign stat.full       = (fill_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign stat.empty      = (fill_reg == '0);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.greater    = (rdata_reg > val_reg);
    assign stat.out_free   = !out_valid_reg || rsp.ready;

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// Controller: sequences one request through the datapath.
`default_nettype none

module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire spq_pkg::dp_stat_t  stat,
    output spq_pkg::dp_cmd_t        cmd
);

    spq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = spq_pkg::ST_DECIDE;
                end
            end
            spq_pkg::ST_DECIDE:
            begin
                priority if (stat.is_dequeue)
                begin
                    state_next = stat.empty ? spq_pkg::ST_FINISH : spq_pkg::ST_DEQ_WAIT;
                end
                else if (stat.full || stat.idx_zero)
                begin
                    state_next = spq_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = spq_pkg::ST_COMPARE;
                end
            end
            spq_pkg::ST_COMPARE:
            begin
                state_next = stat.greater ? spq_pkg::ST_DECIDE : spq_pkg::ST_FINISH;
            end
            spq_pkg::ST_DEQ_WAIT:
            begin
                state_next = spq_pkg::ST_FINISH;
            end
            spq_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.status = spq_pkg::STATUS_OK;
        req_ready = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            spq_pkg::ST_DECIDE:
            begin
                priority if (stat.is_dequeue)
                begin
                    if (stat.empty)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = spq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.read = 1'b1;
                    end
                end
                else if (stat.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = spq_pkg::STATUS_FULL;
                end
                else if (stat.idx_zero)
                begin
                    cmd.place = 1'b1;
                end
                else
                begin
                    cmd.read = 1'b1;
                end
            end
            spq_pkg::ST_COMPARE:
            begin
                // Move larger entries up; stop at first entry not above
                if (stat.greater)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    cmd.place = 1'b1;
                end
            end
            spq_pkg::ST_DEQ_WAIT:
            begin
                cmd.take = 1'b1;
            end
            spq_pkg::ST_FINISH:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [spq_pkg::DATA_W-1:0]      rsp_value_out,
    input wire logic [1:0]                      rsp_status,
    input wire logic                            rsp_now_empty
);

    // A rsp beat stays until taken
    `SPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out), "rsp beat dropped or changed while stalled")

    // One request at a time: no request taken right after another
    `SPQ_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request accepted while another is in work")

    // Empty dequeue reports zero and an empty queue
    `SPQ_ASSERT(a_empty_result, rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY |-> rsp_value_out == '0 && rsp_now_empty, "bad empty-dequeue result")

    // Dropped enqueue reports zero and a non-empty queue
    `SPQ_ASSERT(a_full_result, rsp_valid && rsp_status == spq_pkg::STATUS_FULL |-> rsp_value_out == '0 && !rsp_now_empty, "bad full-enqueue result")

    // No result beat in reset
    `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp_valid, "rsp valid during reset")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_status    (rsp.status),
    .rsp_now_empty (rsp.now_empty)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted max-priority queue: directed table, then random.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 730;
    localparam int QUIET_ITEMS  = 100;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [spq_pkg::DATA_W-1:0] value_out;
        spq_pkg::status_t                  status;
        logic                              now_empty;
    } pq_result_t;

    typedef struct {
        spq_pkg::opcode_t                  op;
        logic signed [spq_pkg::DATA_W-1:0] arg;
        int                                reps;
        bit                                typed;
        pq_result_t                        want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Held values in descending order, newest first among equals.
    logic signed [spq_pkg::DATA_W-1:0] held_values [$];
    pq_result_t                        pending_results [$];

    bit quiet_tail = 1'b0;
    int errors = 0;
    int idle_cycles = 0;
    int enq_count = 0;
    int deq_count = 0;
    int full_hits = 0;
    int empty_hits = 0;
    int results_seen = 0;
    int deepest_fill = 0;

    stim_row_t directed_rows [0:9] = '{
        '{spq_pkg::OP_DEQUEUE, 32'h0000_0000, 1, 1'b1,
          '{32'h0000_0000, spq_pkg::STATUS_EMPTY, 1'b1}},
        '{spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 1, 1'b1,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'h8000_0000, 1, 1'b1,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'h0000_0000, 1, 1'b0,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1, 1'b0,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'h0000_0001, 11, 1'b0,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1, 1'b0,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_ENQUEUE, 32'h0000_0064, 1, 1'b1,
          '{32'h0000_0000, spq_pkg::STATUS_FULL, 1'b0}},
        '{spq_pkg::OP_DEQUEUE, 32'h0000_0000, 1, 1'b1,
          '{32'h7FFF_FFFF, spq_pkg::STATUS_OK, 1'b0}},
        '{spq_pkg::OP_DEQUEUE, 32'h1234_5678, 1, 1'b0,
          '{32'h0000_0000, spq_pkg::STATUS_OK, 1'b0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pq_result_t predict_queue_op(
        input spq_pkg::opcode_t op,
        input logic signed [spq_pkg::DATA_W-1:0] v);
        pq_result_t r;
        int pos;
        r.value_out = '0;
        r.status    = spq_pkg::STATUS_OK;
        if (op == spq_pkg::OP_ENQUEUE)
        begin
            if (held_values.size() >= spq_pkg::DEPTH)
                r.status = spq_pkg::STATUS_FULL;
            else
            begin
                pos = held_values.size();
                for (int i = 0; i < held_values.size(); i++)
                begin
                    if (held_values[i] <= v)
                    begin
                        pos = i;
                        break;
                    end
                end
                held_values.insert(pos, v);
            end
        end
        else
        begin
            if (held_values.size() == 0)
                r.status = spq_pkg::STATUS_EMPTY;
            else
                r.value_out = held_values.pop_front();
        end
        r.now_empty = (held_values.size() == 0);
        return r;
    endfunction

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        logic signed [spq_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2, 3, 4: v = int'($urandom_range(0, 16)) - 8;
            5: v = (held_values.size() != 0) ?
                   held_values[$urandom_range(0, held_values.size() - 1)] : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Drive one request beat, hold it until accepted, then record its expected result.
    task automatic send_item(input spq_pkg::opcode_t op,
                             input logic signed [spq_pkg::DATA_W-1:0] v,
                             input bit use_typed, input pq_result_t typed_want);
        pq_result_t predicted;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.value_in <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_queue_op(op, v);
        pending_results.push_back(use_typed ? typed_want : predicted);
        if (op == spq_pkg::OP_ENQUEUE)
            enq_count++;
        else
            deq_count++;
        if (predicted.status == spq_pkg::STATUS_FULL)
            full_hits++;
        if (predicted.status == spq_pkg::STATUS_EMPTY)
            empty_hits++;
        if (held_values.size() > deepest_fill)
            deepest_fill = held_values.size();
    endtask

    // Response side: random stall bursts, none started in the quiet tail.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pq_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, got value_out %0d status %0d %s %0d",
                         $time, rsp_ch.value_out, rsp_ch.status, "now_empty",
                         rsp_ch.now_empty);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.value_out !== want.value_out)
                begin
                    $display("%0t: value_out mismatch, expected %0d, got %0d",
                             $time, want.value_out, rsp_ch.value_out);
                    errors++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.now_empty !== want.now_empty)
                begin
                    $display("%0t: now_empty mismatch, expected %0d, got %0d",
                             $time, want.now_empty, rsp_ch.now_empty);
                    errors++;
                end
            end
        end
    end

    // Abort when no beat moves on either channel for too long.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int enq_pct;
        int phase_left;
        spq_pkg::opcode_t op;
        pq_result_t unused_want;
        enq_pct = 50;
        phase_left = 0;
        unused_want = '0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= spq_pkg::OP_ENQUEUE;
        req_ch.value_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_item(directed_rows[r].op, directed_rows[r].arg,
                          directed_rows[r].typed, directed_rows[r].want);

        // Phases lean toward filling, draining or neither so both boundaries are hit often.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
                phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE : spq_pkg::OP_DEQUEUE;
            send_item(op, (op == spq_pkg::OP_ENQUEUE) ? pick_value() : $urandom, 1'b0,
                      unused_want);
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d enqueues and %0d dequeues, %0d results checked, %0d errors.",
                 enq_count, deq_count, results_seen, errors);
        $display("Full rejections %0d, empty rejections %0d, deepest fill %0d of %0d.",
                 full_hits, empty_hits, deepest_fill, spq_pkg::DEPTH);
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_datapath.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue_top.sv
rtl/core/spq_checker.sv
tb/testbench.sv
